// ----- rtl/far_pkg.sv -----
// ----------------------------------------------------------------------------
// far_pkg: shared types and constants for the fraction adder
// widths of operands and results, and the queue entry between front and back
// ----------------------------------------------------------------------------
package far_pkg;

    localparam int VALUE_WIDTH = 15;
    localparam int NUM_WIDTH   = 31;
    localparam int DEN_WIDTH   = 30;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
    localparam int SHIFT_WIDTH = $clog2(SUM_WIDTH + 1);
    localparam int QBIT_WIDTH  = $clog2(SUM_WIDTH);

    typedef enum logic [1:0] {
        CLS_NORMAL,
        CLS_ZERO_DEN,
        CLS_ZERO_NUM
    } t_class;

    typedef struct packed {
        t_class                 cls;
        logic [SUM_WIDTH-1:0]   num;
        logic [PROD_WIDTH-1:0]  den;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/far_if.sv -----
// ----------------------------------------------------------------------------
// far_in_if / far_out_if: valid-ready channels of the fraction adder
// a transfer happens when valid and ready are both high
// ----------------------------------------------------------------------------
interface far_in_if;
    logic                          valid;
    logic                          ready;
    logic [far_pkg::VALUE_WIDTH-1:0] num_a;
    logic [far_pkg::VALUE_WIDTH-1:0] den_a;
    logic [far_pkg::VALUE_WIDTH-1:0] num_b;
    logic [far_pkg::VALUE_WIDTH-1:0] den_b;
    modport source (output valid, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

interface far_out_if;
    logic                          valid;
    logic                          ready;
    logic [far_pkg::NUM_WIDTH-1:0] sum_num;
    logic [far_pkg::DEN_WIDTH-1:0] sum_den;
    logic [far_pkg::DEN_WIDTH-1:0] divisor;
    modport source (output valid, sum_num, sum_den, divisor, input ready);
    modport sink   (input valid, sum_num, sum_den, divisor, output ready);
endinterface

// ----- rtl/fraction_add_reduce.sv -----
// ----------------------------------------------------------------------------
// fraction_add_reduce: adds a/b + c/d and reduces the sum by its gcd
// front pipeline, job queue and iterative gcd/divide back end
// ----------------------------------------------------------------------------
// One item at a time goes through the back end: a binary gcd with one shift
// or subtract per cycle, then two restoring divisions by the gcd; a zero
// numerator or zero denominator skips both. The front end multiplies in
// two stages and a two-entry queue holds work while the back end is busy;
// the result register frees the back end once taken.
module fraction_add_reduce (
    input  logic     i_clk,
    input  logic     i_rst_n,
    far_in_if.sink   in_ch,
    far_out_if.source out_ch
);
    import far_pkg::*;

    logic w_f_valid, w_f_ready, w_b_valid, w_b_ready;
    t_job w_f_job, w_b_job;

    far_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_job_valid(w_f_valid), .i_job_ready(w_f_ready), .o_job(w_f_job)
    );

    far_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(w_f_valid), .o_wr_ready(w_f_ready), .i_wr_job(w_f_job),
        .o_rd_valid(w_b_valid), .i_rd_ready(w_b_ready), .o_rd_job(w_b_job)
    );

    far_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_b_valid), .o_job_ready(w_b_ready), .i_job(w_b_job),
        .out_ch(out_ch)
    );

endmodule

// ----- rtl/far_front.sv -----
// ----------------------------------------------------------------------------
// far_front: accepts operands, forms cross products and classifies the sum
// two-stage: register operands, then register products; sum and class form from them into the job
// ----------------------------------------------------------------------------
module far_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    far_in_if.sink             in_ch,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output far_pkg::t_job      o_job
);
    import far_pkg::*;

    logic                    r_op_valid, n_op_valid;
    logic [VALUE_WIDTH-1:0]  r_a, r_b, r_c, r_d;
    logic                    r_p_valid, n_p_valid;
    logic [PROD_WIDTH-1:0]   r_ad, r_cb, r_bd;
    logic [SUM_WIDTH-1:0]    w_sum;
    logic                    w_p_adv, w_op_adv;

    assign w_p_adv  = !r_p_valid || i_job_ready;
    assign w_op_adv = !r_op_valid || w_p_adv;
    assign in_ch.ready = w_op_adv;

    always_comb begin
        n_op_valid = r_op_valid;
        if (w_op_adv) begin
            n_op_valid = in_ch.valid;
        end
        n_p_valid = r_p_valid;
        if (w_p_adv) begin
            n_p_valid = r_op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid <= 1'b0;
            r_p_valid  <= 1'b0;
        end else begin
            r_op_valid <= n_op_valid;
            r_p_valid  <= n_p_valid;
        end
        if (w_op_adv && in_ch.valid) begin
            r_a <= in_ch.num_a;
            r_b <= in_ch.den_a;
            r_c <= in_ch.num_b;
            r_d <= in_ch.den_b;
        end
        if (w_p_adv && r_op_valid) begin
            r_ad <= PROD_WIDTH'(r_a) * PROD_WIDTH'(r_d);
            r_cb <= PROD_WIDTH'(r_c) * PROD_WIDTH'(r_b);
            r_bd <= PROD_WIDTH'(r_b) * PROD_WIDTH'(r_d);
        end
    end

    assign w_sum = SUM_WIDTH'(r_ad) + SUM_WIDTH'(r_cb);

    always_comb begin
        o_job.num = w_sum;
        o_job.den = r_bd;
        if (r_bd == '0) begin
            o_job.cls = CLS_ZERO_DEN;
        end else if (w_sum == '0) begin
            o_job.cls = CLS_ZERO_NUM;
        end else begin
            o_job.cls = CLS_NORMAL;
        end
    end

    assign o_job_valid = r_p_valid;

endmodule

// ----- rtl/far_queue.sv -----
// ----------------------------------------------------------------------------
// far_queue: short fifo of classified jobs between front and back
// ----------------------------------------------------------------------------
module far_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  far_pkg::t_job  i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output far_pkg::t_job  o_rd_job
);
    import far_pkg::*;

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wp, r_rp;
    logic [QCNT_WIDTH-1:0] r_cnt;
    logic                  w_wr, w_rd;

    assign o_wr_ready = r_cnt != QCNT_WIDTH'(QUEUE_DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_WIDTH'(w_wr) - QCNT_WIDTH'(w_rd);
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

endmodule

// ----- rtl/far_back.sv -----
// ----------------------------------------------------------------------------
// far_back: binary gcd and two restoring divisions, one step per cycle
// result sits in an output register until the transfer
// ----------------------------------------------------------------------------
module far_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  far_pkg::t_job  i_job,
    far_out_if.source      out_ch
);
    import far_pkg::*;

    t_state                 r_state, n_state;
    logic [SUM_WIDTH-1:0]   r_x, r_y, r_num, r_quo, r_rem, r_g;
    logic [PROD_WIDTH-1:0]  r_den;
    logic [SHIFT_WIDTH-1:0] r_shift;
    logic [QBIT_WIDTH-1:0]  r_bit;
    logic                   r_ovalid;
    logic [NUM_WIDTH-1:0]   r_onum;
    logic [DEN_WIDTH-1:0]   r_oden, r_odiv;
    logic [SUM_WIDTH-1:0]   w_dvd, w_trial;
    logic                   w_take, w_free;

    assign w_free      = !r_ovalid || out_ch.ready;
    assign o_job_ready = r_state == ST_IDLE;
    assign w_take      = i_job_valid && o_job_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.cls == CLS_NORMAL) ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (r_x[0] || r_y[0]) begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (r_y == '0) begin
                    n_state = ST_DIV_NUM;
                end
            end
            ST_DIV_NUM: begin
                if (r_bit == '0) begin
                    n_state = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                if (r_bit == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_dvd   = (r_state == ST_DIV_NUM) ? r_num : SUM_WIDTH'(r_den);
    assign w_trial = {r_rem[SUM_WIDTH-2:0], w_dvd[r_bit]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_free) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    r_num   <= i_job.num;
                    r_den   <= i_job.den;
                    r_x     <= i_job.num;
                    r_y     <= SUM_WIDTH'(i_job.den);
                    r_shift <= '0;
                    if (i_job.cls == CLS_ZERO_DEN) begin
                        r_quo <= i_job.num;
                        r_rem <= '0;
                        r_g   <= SUM_WIDTH'(1);
                    end else begin
                        r_quo <= '0;
                        r_rem <= SUM_WIDTH'(1);
                        r_g   <= SUM_WIDTH'(i_job.den);
                    end
                end
            end
            ST_SHIFT: begin
                if (!(r_x[0] || r_y[0])) begin
                    r_x     <= r_x >> 1;
                    r_y     <= r_y >> 1;
                    r_shift <= r_shift + 1'b1;
                end
            end
            ST_GCD: begin
                if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (r_y == '0) begin
                    r_g   <= r_x << r_shift;
                    r_bit <= QBIT_WIDTH'(SUM_WIDTH - 1);
                    r_rem <= '0;
                    r_quo <= '0;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= r_y;
                    r_y <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
            ST_DIV_NUM, ST_DIV_DEN: begin
                if (r_bit == '0 && r_state == ST_DIV_NUM) begin
                    r_num <= {r_quo[SUM_WIDTH-2:0], w_trial >= r_g};
                    r_rem <= '0;
                    r_quo <= '0;
                end else if (w_trial >= r_g) begin
                    r_rem <= w_trial - r_g;
                    r_quo <= {r_quo[SUM_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[SUM_WIDTH-2:0], 1'b0};
                end
                if (r_bit == '0) begin
                    r_bit <= QBIT_WIDTH'(SUM_WIDTH - 1);
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
            ST_DONE: begin
                if (w_free) begin
                    r_odiv <= DEN_WIDTH'(r_g);
                    if (r_num == '0 || r_den == '0) begin
                        r_onum <= NUM_WIDTH'(r_quo);
                        r_oden <= DEN_WIDTH'(r_rem);
                    end else begin
                        r_onum <= NUM_WIDTH'(r_num);
                        r_oden <= DEN_WIDTH'(r_quo);
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid   = r_ovalid;
    assign out_ch.sum_num = r_onum;
    assign out_ch.sum_den = r_oden;
    assign out_ch.divisor = r_odiv;

endmodule

// ----- rtl/far_checker.sv -----
// ----------------------------------------------------------------------------
// far_checker: port-level checks of the fraction adder
// ----------------------------------------------------------------------------
module far_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [far_pkg::NUM_WIDTH-1:0] sum_num,
    input logic [far_pkg::DEN_WIDTH-1:0] sum_den,
    input logic [far_pkg::DEN_WIDTH-1:0] divisor
);
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_num)
        && $stable(sum_den) && $stable(divisor)) else $error("result dropped");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> divisor != '0) else $error("zero divisor");
    a_no_out_without_in: assert property (@(posedge i_clk)
        !i_rst_n ##1 !(in_valid && in_ready) |=> !out_valid)
        else $error("result without transfer");
endmodule

bind fraction_add_reduce far_checker u_far_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sum_num(out_ch.sum_num), .sum_den(out_ch.sum_den),
    .divisor(out_ch.divisor)
);

// ----- verif/fraction_add_reduce_tb.sv -----
// ----------------------------------------------------------------------------
// fraction_add_reduce_tb: self-checking bench for the fraction adder
// drives fraction pairs over the input channel, predicts each reduced sum
// with a local gcd, and checks every result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fraction_add_reduce_tb;
    import far_pkg::*;

    typedef struct {
        logic [NUM_WIDTH-1:0] sum_num;
        logic [DEN_WIDTH-1:0] sum_den;
        logic [DEN_WIDTH-1:0] divisor;
    } t_sum;

    class sum_scoreboard;
        t_sum pending[$];
        int   errors;
        int   checked;

        function logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
            int unsigned sh;
            logic [63:0] t;
            sh = 0;
            while (((x | y) & 1) == 0) begin
                x = x >> 1;
                y = y >> 1;
                sh++;
            end
            while ((x & 1) == 0) x = x >> 1;
            while (y != 0) begin
                while ((y & 1) == 0) y = y >> 1;
                if (x > y) begin
                    t = x;
                    x = y;
                    y = t;
                end
                y = y - x;
            end
            return x << sh;
        endfunction

        function void note_operands(logic [VALUE_WIDTH-1:0] a, logic [VALUE_WIDTH-1:0] b,
                                    logic [VALUE_WIDTH-1:0] c, logic [VALUE_WIDTH-1:0] d);
            logic [63:0] num, den, rn, rd, g;
            t_sum s;
            num = 64'(a) * 64'(d) + 64'(c) * 64'(b);
            den = 64'(b) * 64'(d);
            if (den == 0) begin
                rn = num;
                rd = 0;
                g = 1;
            end else if (num == 0) begin
                rn = 0;
                rd = 1;
                g = den;
            end else begin
                g = gcd_of(num, den);
                rn = num / g;
                rd = den / g;
            end
            s.sum_num = rn[NUM_WIDTH-1:0];
            s.sum_den = rd[DEN_WIDTH-1:0];
            s.divisor = g[DEN_WIDTH-1:0];
            pending.push_back(s);
        endfunction

        task check_sum(logic [NUM_WIDTH-1:0] n, logic [DEN_WIDTH-1:0] d,
                       logic [DEN_WIDTH-1:0] g);
            t_sum s;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending");
                return;
            end
            s = pending.pop_front();
            if (n !== s.sum_num)
                report_mismatch($sformatf("sum_num %0d want %0d", n, s.sum_num));
            if (d !== s.sum_den)
                report_mismatch($sformatf("sum_den %0d want %0d", d, s.sum_den));
            if (g !== s.divisor)
                report_mismatch($sformatf("divisor %0d want %0d", g, s.divisor));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle = 29;
    int   recv_idle = 55;
    bit   hold_recv = 1'b0;
    int   n_sent = 0;
    sum_scoreboard sb = new();

    far_in_if  in_ch();
    far_out_if out_ch();

    fraction_add_reduce dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("fraction_add_reduce: mismatch");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("error at %0t: %s", $realtime, msg);
        sb.errors++;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.num_a = '0;
        in_ch.den_a = '0;
        in_ch.num_b = '0;
        in_ch.den_b = '0;
        out_ch.ready = 1'b0;
    end

    // result side: random ready, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_recv)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_sum(out_ch.sum_num, out_ch.sum_den, out_ch.divisor);
    end

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return VALUE_WIDTH'($urandom_range(15));
            3: return VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1);
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    // one transfer; the sender may idle first, valid stays up for the next one
    task automatic send_item(logic [VALUE_WIDTH-1:0] a, logic [VALUE_WIDTH-1:0] b,
                             logic [VALUE_WIDTH-1:0] c, logic [VALUE_WIDTH-1:0] d);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.num_a <= a;
        in_ch.den_a <= b;
        in_ch.num_b <= c;
        in_ch.den_b <= d;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_operands(a, b, c, d);
        n_sent++;
        @(negedge i_clk);
    endtask

    // end of a burst
    task automatic stop_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_random(int count);
        logic [VALUE_WIDTH-1:0] b, d;
        repeat (count) begin
            b = pick_value();
            d = pick_value();
            // denominators are mostly nonzero
            if ($urandom_range(19) != 0 && b == 0) b = 1;
            if ($urandom_range(19) != 0 && d == 0) d = VALUE_WIDTH'($urandom_range(32767, 1));
            send_item(pick_value(), b, pick_value(), d);
        end
    endtask

    initial begin
        int waited;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item('1, '1, '1, '1);
        send_item(0, 1, 0, 1);
        send_item(0, '1, 0, '1);
        send_item(1, 1, 1, 1);
        send_item(3, 0, 5, 7);
        send_item(3, 7, 5, 0);
        send_item(0, 0, 0, 0);
        send_item(9, 0, 4, 0);
        send_item(1, 2, 1, 2);
        send_item(1, 3, 2, 3);
        send_item(0, 5, 7, 5);
        send_item('1, 1, '1, 1);
        send_item(1, '1, 1, '1);
        send_item(15'h5555, 15'h2aaa, 15'h2aaa, 15'h5555);
        send_item(15'h4000, 15'h4000, 15'h4000, 15'h4000);
        send_item(32749, 32719, 32717, 32707);

        send_random(190);
        stop_input();

        // long receiver hold-off while items keep coming
        @(negedge i_clk);
        hold_recv = 1'b1;
        fork
            begin
                waited = 0;
                while (waited < 1500) begin
                    @(posedge i_clk);
                    waited++;
                end
                hold_recv = 1'b0;
            end
            send_random(8);
        join

        send_idle = 55;
        recv_idle = 29;
        send_random(190);
        send_idle = 0;
        recv_idle = 0;
        send_random(200);
        stop_input();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("sent %0d fraction pairs, checked %0d reduced sums", n_sent, sb.checked);
        $display("covered zero sums, zero denominators, extremes and back-pressure");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("fraction_add_reduce: match");
        else
            $display("fraction_add_reduce: mismatch");
        $finish;
    end

endmodule

// ----- fraction_add_reduce.f -----
rtl/far_pkg.sv
rtl/far_if.sv
rtl/far_front.sv
rtl/far_queue.sv
rtl/far_back.sv
rtl/fraction_add_reduce.sv
rtl/far_checker.sv
verif/fraction_add_reduce_tb.sv
